[design/km2d_pkg.sv]
// Package for the 2-D k-means clustering block.
// Holds payload structs, command codes, state enum and size constants.
`timescale 1ns / 1ps
package km2d_pkg;
	localparam int MAX_POINTS_DEF   = 4096;
	localparam int MAX_CLUSTERS_DEF = 16;
	localparam int COORD_BITS_DEF   = 10;

	typedef enum logic [1:0] {
		FUNC_POINT  = 2'd0,
		FUNC_CENTER = 2'd1,
		FUNC_RUN    = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	localparam logic REG_CLUSTERS = 1'b0;
	localparam logic REG_LIMIT    = 1'b1;

	typedef struct packed {
		logic [1:0] func;
		logic [3:0] center_slot;
		logic [9:0] coord_x;
		logic [9:0] coord_y;
	} in_beat_t;

	typedef struct packed {
		logic [3:0]  result_center;
		logic [9:0]  center_x;
		logic [9:0]  center_y;
		logic [12:0] member_total;
		logic        converged;
		logic        last;
	} out_beat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PREP,
		ST_RD,
		ST_DIST,
		ST_ACC,
		ST_UPD,
		ST_DIV,
		ST_DIVEND,
		ST_PASSEND,
		ST_OUT
	} state_t;
endpackage

[design/km2d_ram.sv]
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
module km2d_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[design/km2d_div.sv]
// Restoring divider, one quotient bit per cycle.
// Uses km2d_pkg for nothing but is sized by parameters.
`timescale 1ns / 1ps
module km2d_div #(
	parameter int NBITS = 29,
	parameter int DBITS = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NBITS-1:0] dividend,
	input  logic [DBITS-1:0] divisor,
	output logic             done,
	output logic [NBITS-1:0] quotient
);
	localparam int CW = $clog2(NBITS + 1);
	logic [NBITS-1:0] num_q;
	logic [DBITS:0]   rem_q;
	logic [DBITS-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [DBITS:0]   trial;
	logic [DBITS:0]   diff;

	assign trial    = {rem_q[DBITS-1:0], num_q[NBITS-1]};
	assign diff     = trial - {1'b0, den_q};
	assign quotient = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NBITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[DBITS]) begin
				rem_q <= diff;
				num_q <= {num_q[NBITS-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[NBITS-2:0], 1'b0};
			end
		end
	end
endmodule

[design/kmeans_2d_point_clustering.sv]
// Top level of the 2-D Lloyd k-means block.
// Depends on km2d_pkg, km2d_ram and km2d_div.
//
// Input channel (in_valid/in_stall/in_data) takes one beat per command:
// point load, center load or run. Loads take effect when accepted. A run
// labels every stored point against each center in turn through one
// shared squared-distance unit, then updates centers through one serial
// divider. A run takes up to iteration_limit passes (one if the limit is
// zero), then one output beat per center in use on out_valid/out_data.
// in_stall is high from the run beat until the last result beat leaves.
// A stalled result beat holds.
// Reset clears point count, centers and config to their defaults; the
// center store has no clearing pass. The sum/count registers are cleared
// at the start of every pass, one cluster per cycle.
`timescale 1ns / 1ps
module kmeans_2d_point_clustering
	import km2d_pkg::*;
#(
	parameter int MAX_POINTS   = MAX_POINTS_DEF,
	parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic [7:0] cfg_data
);
	localparam int PA   = $clog2(MAX_POINTS);
	localparam int PC   = $clog2(MAX_POINTS + 1);
	localparam int KA   = $clog2(MAX_CLUSTERS);
	localparam int KC   = $clog2(MAX_CLUSTERS + 1);
	localparam int CB   = COORD_BITS;
	localparam int SB   = CB + PC;
	localparam int DB   = 2 * CB + 1;

	state_t st_q, st_d;
	logic [4:0]     ccount_q;
	logic [7:0]     limit_q;
	logic [PC-1:0]  ptotal_q;
	logic [CB-1:0]  cx_q [MAX_CLUSTERS];
	logic [CB-1:0]  cy_q [MAX_CLUSTERS];
	logic [SB-1:0]  sx_q [MAX_CLUSTERS];
	logic [SB-1:0]  sy_q [MAX_CLUSTERS];
	logic [PC-1:0]  mc_q [MAX_CLUSTERS];
	logic [KC-1:0]  kused_q;
	logic [7:0]     pass_q;
	logic [PC-1:0]  p_q;
	logic [KA-1:0]  k_q;
	logic [KA-1:0]  best_q;
	logic [DB-1:0]  bestd_q;
	logic           moved_q;
	logic           conv_q;
	logic           axis_q;
	logic [CB-1:0]  px_q, py_q;
	logic [CB-1:0]  nx_q;
	logic           ov_q;
	out_beat_t      od_q;

	logic           in_acc, out_acc;
	logic [2*CB-1:0] rdata;
	logic [DB-1:0]  sqd;
	logic [CB-1:0]  dx, dy, in_x, in_y;
	logic           div_start, div_done;
	logic [SB-1:0]  quo;
	logic [KA-1:0]  klast;

	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = ov_q && !out_stall;
	assign in_stall  = (st_q != ST_IDLE);
	assign out_valid = ov_q;
	assign out_data  = od_q;
	assign in_x      = CB'(in_data.coord_x);
	assign in_y      = CB'(in_data.coord_y);
	assign klast     = KA'(kused_q - 1'b1);

	km2d_ram #(.WIDTH(2 * CB), .DEPTH(MAX_POINTS)) u_pts (
		.clk(clk),
		.we(in_acc && in_data.func == FUNC_POINT && ptotal_q < PC'(MAX_POINTS)),
		.waddr(PA'(ptotal_q)),
		.wdata({in_x, in_y}),
		.raddr(PA'(p_q)),
		.rdata(rdata)
	);

	// shared distance unit: one center per cycle
	assign dx   = (px_q > cx_q[k_q]) ? px_q - cx_q[k_q] : cx_q[k_q] - px_q;
	assign dy   = (py_q > cy_q[k_q]) ? py_q - cy_q[k_q] : cy_q[k_q] - py_q;
	assign sqd  = DB'({{CB{1'b0}}, dx} * {{CB{1'b0}}, dx}) +
		DB'({{CB{1'b0}}, dy} * {{CB{1'b0}}, dy});

	assign div_start = (st_q == ST_DIV);
	km2d_div #(.NBITS(SB), .DBITS(PC)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(axis_q ? sy_q[k_q] : sx_q[k_q]),
		.divisor(mc_q[k_q]),
		.done(div_done),
		.quotient(quo)
	);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:    if (in_acc && in_data.func == FUNC_RUN) st_d = ST_CLEAR;
			ST_CLEAR:   if (k_q == klast) st_d = ST_PREP;
			ST_PREP:    st_d = (p_q == ptotal_q) ? ST_UPD : ST_RD;
			ST_RD:      st_d = ST_DIST;
			ST_DIST:    if (k_q == klast) st_d = ST_ACC;
			ST_ACC:     st_d = ST_PREP;
			ST_UPD:     st_d = (mc_q[k_q] == '0) ? ST_DIVEND : ST_DIV;
			ST_DIV:     st_d = ST_DIVEND;
			ST_DIVEND: begin
				if (mc_q[k_q] == '0 || (div_done && axis_q)) begin
					st_d = (k_q == klast) ? ST_PASSEND : ST_UPD;
				end else if (div_done) begin
					st_d = ST_DIV;
				end
			end
			ST_PASSEND: st_d = (!moved_q || (pass_q + 8'd1) == limit_q || limit_q == '0) ?
				ST_OUT : ST_CLEAR;
			ST_OUT:     if (!ov_q || out_acc) begin
				if (ov_q && od_q.last) st_d = ST_IDLE;
			end
			default:    st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			ccount_q <= 5'd2;
			limit_q  <= 8'd64;
			ptotal_q <= '0;
			ov_q     <= 1'b0;
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				cx_q[i] <= '0;
				cy_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				if (cfg_index == REG_CLUSTERS) ccount_q <= cfg_data[4:0];
				else limit_q <= cfg_data;
			end
			if (in_acc && in_data.func == FUNC_POINT && ptotal_q < PC'(MAX_POINTS)) begin
				ptotal_q <= ptotal_q + 1'b1;
			end
			if (in_acc && in_data.func == FUNC_CENTER &&
				32'(in_data.center_slot) < MAX_CLUSTERS) begin
				cx_q[KA'(in_data.center_slot)] <= in_x;
				cy_q[KA'(in_data.center_slot)] <= in_y;
			end
			// new center coordinates land once both axes are divided; an empty cluster's center goes to zero
			if (st_q == ST_DIVEND && mc_q[k_q] == '0) begin
				cx_q[k_q] <= '0;
				cy_q[k_q] <= '0;
			end else if (st_q == ST_DIVEND && div_done && axis_q) begin
				cx_q[k_q] <= nx_q;
				cy_q[k_q] <= CB'(quo);
			end
			if (out_acc) ov_q <= 1'b0;
			if (st_q == ST_OUT && (!ov_q || out_acc) && !(ov_q && od_q.last)) begin
				ov_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (ccount_q == '0) kused_q <= KC'(1);
				else if (32'(ccount_q) > MAX_CLUSTERS) kused_q <= KC'(MAX_CLUSTERS);
				else kused_q <= KC'(ccount_q);
				pass_q <= '0;
				k_q    <= '0;
			end
			ST_CLEAR: begin
				sx_q[k_q] <= '0;
				sy_q[k_q] <= '0;
				mc_q[k_q] <= '0;
				k_q       <= (k_q == klast) ? '0 : k_q + 1'b1;
				p_q       <= '0;
				moved_q   <= 1'b0;
			end
			ST_PREP: begin
				k_q <= '0;
			end
			ST_RD: begin
				px_q <= rdata[2*CB-1:CB];
				py_q <= rdata[CB-1:0];
			end
			ST_DIST: begin
				if (k_q == '0 || sqd < bestd_q) begin
					bestd_q <= sqd;
					best_q  <= k_q;
				end
				if (k_q != klast) k_q <= k_q + 1'b1;
			end
			ST_ACC: begin
				sx_q[best_q] <= sx_q[best_q] + SB'(px_q);
				sy_q[best_q] <= sy_q[best_q] + SB'(py_q);
				mc_q[best_q] <= mc_q[best_q] + 1'b1;
				p_q          <= p_q + 1'b1;
				k_q          <= '0;
			end
			ST_UPD: begin
				axis_q <= 1'b0;
			end
			ST_DIV: ;
			ST_DIVEND: begin
				if (mc_q[k_q] == '0) begin
					if (cx_q[k_q] != '0 || cy_q[k_q] != '0) moved_q <= 1'b1;
					if (k_q != klast) k_q <= k_q + 1'b1;
				end else if (div_done && !axis_q) begin
					nx_q   <= CB'(quo);
					axis_q <= 1'b1;
				end else if (div_done) begin
					if (nx_q != cx_q[k_q] || CB'(quo) != cy_q[k_q]) moved_q <= 1'b1;
					if (k_q != klast) k_q <= k_q + 1'b1;
				end
			end
			ST_PASSEND: begin
				pass_q <= pass_q + 1'b1;
				conv_q <= !moved_q;
				k_q    <= '0;
			end
			ST_OUT: begin
				if ((!ov_q || out_acc) && !(ov_q && od_q.last)) begin
					od_q.result_center <= 4'(k_q);
					od_q.center_x      <= 10'(cx_q[k_q]);
					od_q.center_y      <= 10'(cy_q[k_q]);
					od_q.member_total  <= 13'(mc_q[k_q]);
					od_q.converged     <= conv_q;
					od_q.last          <= (k_q == klast);
					k_q                <= k_q + 1'b1;
				end
			end
			default: ;
		endcase
	end
endmodule

[verif/kmeans_2d_point_clustering_test.sv]
// Testbench for the 2-D Lloyd k-means block: a directed table and random phases,
// with results checked against an in-bench clustering predictor.
// Depends on km2d_pkg and kmeans_2d_point_clustering.
`timescale 1ns / 1ps
module kmeans_2d_point_clustering_test
	import km2d_pkg::*;
();

	localparam int NPTS = MAX_POINTS_DEF;
	localparam int NCL  = MAX_CLUSTERS_DEF;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		bit        is_cfg;
		logic      reg_sel;
		logic [7:0] reg_val;
		in_beat_t  cmd;
		int        n_typed;
		out_beat_t typed0;
		out_beat_t typed1;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_beat_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_CLUSTERS;
	logic [7:0] cfg_data = '0;

	// predictor state
	int unsigned pt_x[NPTS];
	int unsigned pt_y[NPTS];
	int unsigned pt_count = 0;
	int unsigned ctr_x[NCL];
	int unsigned ctr_y[NCL];
	int unsigned members[NCL];
	logic [4:0] clusters_reg = 5'd2;
	logic [7:0] limit_reg = 8'd64;

	out_beat_t centers_due[$];
	step_t plan[$];
	int errors = 0;
	longint cycles = 0;
	bit quiet = 1'b0;
	int out_hold = 0;
	int draw;

	kmeans_2d_point_clustering DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout", $time);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic check_field(input string fname, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t %s mismatch: expected %0d actual %0d", $time, fname, want, got);
			errors++;
		end
	endtask

	function automatic void due_add(out_beat_t r);
		centers_due = {centers_due, r};
	endfunction

	function automatic void plan_add(step_t s);
		plan = {plan, s};
	endfunction

	// result side: check each beat, then draw the next stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_hold = 0;
		end else if (out_valid && !out_stall) begin
			if (centers_due.size() == 0) begin
				$display("%0t unexpected result beat: actual %p", $time, out_data);
				errors++;
			end else begin
				out_beat_t e;
				e = centers_due.pop_front();
				check_field("result_center", e.result_center, out_data.result_center);
				check_field("center_x", e.center_x, out_data.center_x);
				check_field("center_y", e.center_y, out_data.center_y);
				check_field("member_total", e.member_total, out_data.member_total);
				check_field("converged", e.converged, out_data.converged);
				check_field("last", e.last, out_data.last);
			end
			draw = quiet ? 0 : $urandom_range(0, 19);
			out_hold = draw;
			out_stall <= (draw != 0);
		end else if (out_hold > 0) begin
			out_hold--;
			out_stall <= (out_hold != 0);
		end
	end

	function automatic longint sq_dist(int unsigned ax, int unsigned ay,
			int unsigned bx, int unsigned by);
		longint dx, dy;
		dx = longint'(ax) - longint'(bx);
		dy = longint'(ay) - longint'(by);
		return dx * dx + dy * dy;
	endfunction

	// one assign-update pass; returns 1 if any center moved
	function automatic bit lloyd_pass(int ku);
		longint sx[NCL];
		longint sy[NCL];
		longint bd, d;
		int best;
		int unsigned nx, ny;
		bit moved;
		moved = 1'b0;
		for (int k = 0; k < ku; k++) begin
			sx[k] = 0;
			sy[k] = 0;
			members[k] = 0;
		end
		for (int p = 0; p < pt_count; p++) begin
			best = 0;
			bd = sq_dist(pt_x[p], pt_y[p], ctr_x[0], ctr_y[0]);
			for (int k = 1; k < ku; k++) begin
				d = sq_dist(pt_x[p], pt_y[p], ctr_x[k], ctr_y[k]);
				if (d < bd) begin
					bd = d;
					best = k;
				end
			end
			sx[best] += pt_x[p];
			sy[best] += pt_y[p];
			members[best]++;
		end
		for (int k = 0; k < ku; k++) begin
			nx = 0;
			ny = 0;
			if (members[k] != 0) begin
				nx = 32'(sx[k] / members[k]);
				ny = 32'(sy[k] / members[k]);
			end
			if (nx != ctr_x[k] || ny != ctr_y[k])
				moved = 1'b1;
			ctr_x[k] = nx;
			ctr_y[k] = ny;
		end
		return moved;
	endfunction

	function automatic void predict_beat(step_t s);
		int ku, lim;
		bit conv;
		out_beat_t r;
		case (s.cmd.func)
			FUNC_POINT: begin
				if (pt_count < NPTS) begin
					pt_x[pt_count] = 32'(s.cmd.coord_x);
					pt_y[pt_count] = 32'(s.cmd.coord_y);
					pt_count++;
				end
			end
			FUNC_CENTER: begin
				ctr_x[s.cmd.center_slot] = 32'(s.cmd.coord_x);
				ctr_y[s.cmd.center_slot] = 32'(s.cmd.coord_y);
			end
			FUNC_RUN: begin
				ku = (clusters_reg == 0) ? 1 : (clusters_reg > NCL ? NCL : int'(clusters_reg));
				lim = (limit_reg == 0) ? 1 : int'(limit_reg);
				conv = 1'b0;
				for (int p = 0; p < lim; p++) begin
					if (!lloyd_pass(ku)) begin
						conv = 1'b1;
						break;
					end
				end
				if (s.n_typed > 0) begin
					due_add(s.typed0);
					if (s.n_typed > 1)
						due_add(s.typed1);
				end else begin
					for (int k = 0; k < ku; k++) begin
						r.result_center = 4'(k);
						r.center_x = 10'(ctr_x[k]);
						r.center_y = 10'(ctr_y[k]);
						r.member_total = 13'(members[k]);
						r.converged = conv;
						r.last = (k + 1 == ku);
						due_add(r);
					end
				end
			end
			default: ;
		endcase
	endfunction

	// drop valid and hold until every pending result has left the block
	task automatic drain();
		in_valid <= 1'b0;
		while (centers_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apply(step_t s);
		int gap;
		if (s.is_cfg) begin
			drain();
			cfg_we <= 1'b1;
			cfg_index <= s.reg_sel;
			cfg_data <= s.reg_val;
			@(posedge clk);
			cfg_we <= 1'b0;
			if (s.reg_sel == REG_CLUSTERS)
				clusters_reg = s.reg_val[4:0];
			else
				limit_reg = s.reg_val;
		end else begin
			gap = quiet ? 0 : $urandom_range(0, 19);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			in_data <= s.cmd;
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
			predict_beat(s);
		end
	endtask

	function automatic step_t cmd_step(func_t f, int slot, int x, int y);
		step_t s;
		s = '{default: 0};
		s.cmd = '{f, 4'(slot), 10'(x), 10'(y)};
		return s;
	endfunction

	function automatic step_t reg_step(logic sel, int val);
		step_t s;
		s = '{default: 0};
		s.is_cfg = 1'b1;
		s.reg_sel = sel;
		s.reg_val = 8'(val);
		return s;
	endfunction

	initial begin
		step_t s;
		int n_pts, n_ctr;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: no points, centers at the origin, two clusters, converged at once
		s = cmd_step(FUNC_RUN, 0, 0, 0);
		s.n_typed = 2;
		s.typed0 = '{4'd0, 10'd0, 10'd0, 13'd0, 1'b1, 1'b0};
		s.typed1 = '{4'd1, 10'd0, 10'd0, 13'd0, 1'b1, 1'b1};
		plan_add(s);
		plan_add(cmd_step(FUNC_NONE, 15, 1023, 1023));
		plan_add(cmd_step(FUNC_POINT, 0, 0, 0));
		plan_add(cmd_step(FUNC_POINT, 0, 1023, 1023));
		plan_add(cmd_step(FUNC_POINT, 0, 1023, 0));
		plan_add(cmd_step(FUNC_POINT, 0, 0, 1023));
		plan_add(cmd_step(FUNC_POINT, 0, 512, 512));
		plan_add(cmd_step(FUNC_CENTER, 0, 0, 0));
		plan_add(cmd_step(FUNC_CENTER, 1, 1023, 1023));
		plan_add(cmd_step(FUNC_CENTER, 15, 5, 5));
		plan_add(cmd_step(FUNC_RUN, 0, 0, 0));
		plan_add(reg_step(REG_CLUSTERS, 16));
		plan_add(reg_step(REG_LIMIT, 1));
		plan_add(cmd_step(FUNC_RUN, 0, 0, 0));
		// zero clusters acts as one
		plan_add(reg_step(REG_CLUSTERS, 0));
		plan_add(cmd_step(FUNC_RUN, 0, 0, 0));
		// too many clusters saturates, zero limit acts as one
		plan_add(reg_step(REG_CLUSTERS, 31));
		plan_add(reg_step(REG_LIMIT, 0));
		plan_add(cmd_step(FUNC_RUN, 0, 0, 0));
		plan_add(reg_step(REG_LIMIT, 255));
		plan_add(reg_step(REG_CLUSTERS, 3));
		// equal centers: ties go to the lowest index
		plan_add(cmd_step(FUNC_CENTER, 0, 100, 0));
		plan_add(cmd_step(FUNC_CENTER, 1, 100, 0));
		plan_add(cmd_step(FUNC_RUN, 0, 0, 0));
		foreach (plan[i])
			apply(plan[i]);

		for (int ph = 0; ph < 10; ph++) begin
			quiet = ($urandom_range(0, 3) == 0);
			apply(reg_step(REG_CLUSTERS, ($urandom_range(0, 7) == 0) ?
				$urandom_range(0, 31) : $urandom_range(1, 16)));
			apply(reg_step(REG_LIMIT, ($urandom_range(0, 7) == 0) ?
				$urandom_range(0, 255) % 12 : $urandom_range(1, 8)));
			n_ctr = $urandom_range(0, 4);
			for (int i = 0; i < n_ctr; i++)
				apply(cmd_step(FUNC_CENTER, $urandom_range(0, 15),
					$urandom_range(0, 1023), $urandom_range(0, 1023)));
			n_pts = $urandom_range(2, 7);
			for (int i = 0; i < n_pts; i++)
				apply(cmd_step(FUNC_POINT, $urandom_range(0, 15),
					$urandom_range(0, 1023), $urandom_range(0, 1023)));
			if ($urandom_range(0, 2) == 0)
				apply(cmd_step(FUNC_NONE, $urandom_range(0, 15),
					$urandom_range(0, 1023), $urandom_range(0, 1023)));
			apply(cmd_step(FUNC_RUN, $urandom_range(0, 15),
				$urandom_range(0, 1023), $urandom_range(0, 1023)));
			if ($urandom_range(0, 1) == 0)
				apply(cmd_step(FUNC_RUN, 0, 0, 0));
		end

		// corner points, then one last run
		quiet = 1'b0;
		apply(cmd_step(FUNC_POINT, 0, 1023, 1023));
		apply(cmd_step(FUNC_POINT, 0, 0, 0));
		apply(cmd_step(FUNC_RUN, 0, 0, 0));

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

[sim.f]
design/km2d_pkg.sv
design/km2d_ram.sv
design/km2d_div.sv
design/kmeans_2d_point_clustering.sv
verif/kmeans_2d_point_clustering_test.sv
